FILE: sv/spwm_pkg.sv
package spwm_pkg;

    // Design size
    localparam int NUM_CHANNELS = 16;
    localparam int COUNT_BITS   = 12;
    localparam int LEVEL_BITS   = 16;
    localparam int CH_IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req_type;

    // Channel register slots within a group of four
    localparam logic [1:0] SLOT_ON_LO  = 2'd0;
    localparam logic [1:0] SLOT_ON_HI  = 2'd1;
    localparam logic [1:0] SLOT_OFF_LO = 2'd2;
    localparam logic [1:0] SLOT_OFF_HI = 2'd3;

    // Register map
    localparam logic [7:0] MODE_ADDR     = 8'h00;
    localparam logic [7:0] PRESCALE_ADDR = 8'hFE;
    localparam logic [7:0] CHAN_BASE     = 8'h06;
    localparam logic [8:0] CHAN_END      = 9'(int'(CHAN_BASE) + 4 * NUM_CHANNELS);
    localparam int         SLEEP_BIT     = 4;

    // Reset values
    localparam logic [7:0] MODE_RESET     = 8'h10;
    localparam logic [7:0] PRESCALE_RESET = 8'd30;

    // Count byte masks
    localparam logic [COUNT_BITS-1:0] LOW_MASK  = COUNT_BITS'(8'hFF);
    localparam logic [7:0]            HIGH_MASK = 8'((1 << (COUNT_BITS - 8)) - 1);

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        t_count off_cnt;
        t_count on_cnt;
    } t_chan;

    typedef t_chan [NUM_CHANNELS-1:0] t_chan_vec;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
    } t_req;

    // Timebase controls from the register file
    typedef struct packed {
        logic       sleep;
        logic [7:0] prescale;
    } t_timer_cfg;

endpackage

FILE: sv/spwm_req_if.sv
interface spwm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;

    modport source (output valid, output req_type, output reg_addr, output write_data,
                    input ready);
    modport sink (input valid, input req_type, input reg_addr, input write_data,
                  output ready);
endinterface

FILE: sv/spwm_rsp_if.sv
interface spwm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [15:0] pwm_levels;

    modport source (output valid, output read_data, output pwm_levels, input ready);
    modport sink (input valid, input read_data, input pwm_levels, output ready);
endinterface

FILE: sv/sixteen_channel_pwm_register_device.sv
// Channel  Dir  Payload                           Moves
// i_req    in   req_type, reg_addr, write_data    one request: write, read or tick
// o_rsp    out  read_data, pwm_levels             one response for each request
//
// A request is latched in an input register, then applied to the registers and
// timebase while its response is loaded into an output register. One request per
// cycle is sustained while each response is taken.
// Synchronous active-low reset: asleep, prescaler 30, all counts and counters zero.
// A stalled response holds the pipeline; the input register still takes a request
// while it is empty.
module sixteen_channel_pwm_register_device (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spwm_req_if.sink   i_req,
    spwm_rsp_if.source o_rsp
);

    logic                            r_in_valid;
    spwm_pkg::t_req                  r_in;
    logic                            r_out_valid;
    logic [7:0]                      r_read_data;
    logic [spwm_pkg::LEVEL_BITS-1:0] r_levels;

    logic                            adv;
    spwm_pkg::t_chan_vec             chan_next;
    spwm_pkg::t_timer_cfg            timer_cfg;
    spwm_pkg::t_count                count_next;
    logic [7:0]                      read_byte;
    logic [spwm_pkg::LEVEL_BITS-1:0] levels;

    // Move a request forward when the response register is free or drains
    assign adv         = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || adv;

    spwm_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_req       (r_in),
        .o_chan_next (chan_next),
        .o_timer_cfg (timer_cfg),
        .o_read_data (read_byte)
    );

    spwm_timebase u_timebase (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (adv && (r_in.req_type == spwm_pkg::REQ_TICK)),
        .i_cfg        (timer_cfg),
        .o_count_next (count_next)
    );

    spwm_levels u_levels (
        .i_chan   (chan_next),
        .i_count  (count_next),
        .o_levels (levels)
    );

    // Hold the input request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
        if (i_req.valid && i_req.ready) begin
            r_in.req_type   <= i_req.req_type;
            r_in.reg_addr   <= i_req.reg_addr;
            r_in.write_data <= i_req.write_data;
        end
    end

    // Load the response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_read_data <= (r_in.req_type == spwm_pkg::REQ_READ) ? read_byte : 8'h00;
            r_levels    <= levels;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_read_data;
    assign o_rsp.pwm_levels = r_levels;

endmodule

FILE: sv/spwm_regfile.sv
module spwm_regfile (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  spwm_pkg::t_req        i_req,
    output spwm_pkg::t_chan_vec   o_chan_next,
    output spwm_pkg::t_timer_cfg  o_timer_cfg,
    output logic [7:0]            o_read_data
);

    logic [7:0]          r_mode;
    logic [7:0]          n_mode;
    logic [7:0]          r_prescale;
    logic [7:0]          n_prescale;
    spwm_pkg::t_chan_vec r_chan;
    spwm_pkg::t_chan_vec n_chan;

    logic                             in_range;
    logic [7:0]                       chan_off;
    logic [spwm_pkg::CH_IDX_BITS-1:0] ch;
    logic [1:0]                       slot;
    logic                             wr;

    // Decode the channel register address
    assign in_range = (i_req.reg_addr >= spwm_pkg::CHAN_BASE)
                   && ({1'b0, i_req.reg_addr} < spwm_pkg::CHAN_END);
    assign chan_off = i_req.reg_addr - spwm_pkg::CHAN_BASE;
    assign ch       = spwm_pkg::CH_IDX_BITS'(chan_off >> 2);
    assign slot     = chan_off[1:0];
    assign wr       = i_en && (i_req.req_type == spwm_pkg::REQ_WRITE);

    // Apply a write request; the prescaler takes a write only while asleep
    always_comb begin
        n_mode     = r_mode;
        n_prescale = r_prescale;
        n_chan     = r_chan;
        if (wr) begin
            if (i_req.reg_addr == spwm_pkg::MODE_ADDR) begin
                n_mode = i_req.write_data;
            end else if (i_req.reg_addr == spwm_pkg::PRESCALE_ADDR) begin
                if (r_mode[spwm_pkg::SLEEP_BIT]) begin
                    n_prescale = i_req.write_data;
                end
            end else if (in_range) begin
                for (int i = 0; i < spwm_pkg::NUM_CHANNELS; i++) begin
                    if (ch == spwm_pkg::CH_IDX_BITS'(i)) begin
                        case (slot)
                            spwm_pkg::SLOT_ON_LO: begin
                                n_chan[i].on_cnt = (r_chan[i].on_cnt & ~spwm_pkg::LOW_MASK)
                                    | spwm_pkg::COUNT_BITS'(i_req.write_data);
                            end
                            spwm_pkg::SLOT_ON_HI: begin
                                n_chan[i].on_cnt = (r_chan[i].on_cnt & spwm_pkg::LOW_MASK)
                                    | (spwm_pkg::COUNT_BITS'(i_req.write_data
                                       & spwm_pkg::HIGH_MASK) << 8);
                            end
                            spwm_pkg::SLOT_OFF_LO: begin
                                n_chan[i].off_cnt = (r_chan[i].off_cnt & ~spwm_pkg::LOW_MASK)
                                    | spwm_pkg::COUNT_BITS'(i_req.write_data);
                            end
                            default: begin
                                n_chan[i].off_cnt = (r_chan[i].off_cnt & spwm_pkg::LOW_MASK)
                                    | (spwm_pkg::COUNT_BITS'(i_req.write_data
                                       & spwm_pkg::HIGH_MASK) << 8);
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Return the addressed register byte
    always_comb begin
        o_read_data = 8'h00;
        if (i_req.reg_addr == spwm_pkg::MODE_ADDR) begin
            o_read_data = r_mode;
        end else if (i_req.reg_addr == spwm_pkg::PRESCALE_ADDR) begin
            o_read_data = r_prescale;
        end else if (in_range) begin
            case (slot)
                spwm_pkg::SLOT_ON_LO:  o_read_data = 8'(r_chan[ch].on_cnt);
                spwm_pkg::SLOT_ON_HI:  o_read_data = 8'(r_chan[ch].on_cnt >> 8)
                                                     & spwm_pkg::HIGH_MASK;
                spwm_pkg::SLOT_OFF_LO: o_read_data = 8'(r_chan[ch].off_cnt);
                default:               o_read_data = 8'(r_chan[ch].off_cnt >> 8)
                                                     & spwm_pkg::HIGH_MASK;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= spwm_pkg::MODE_RESET;
            r_prescale <= spwm_pkg::PRESCALE_RESET;
            r_chan     <= '0;
        end else begin
            r_mode     <= n_mode;
            r_prescale <= n_prescale;
            r_chan     <= n_chan;
        end
    end

    assign o_chan_next          = n_chan;
    assign o_timer_cfg.sleep    = r_mode[spwm_pkg::SLEEP_BIT];
    assign o_timer_cfg.prescale = r_prescale;

endmodule

FILE: sv/spwm_timebase.sv
module spwm_timebase (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  spwm_pkg::t_timer_cfg i_cfg,
    output spwm_pkg::t_count     o_count_next
);

    logic [7:0]       r_div;
    logic [7:0]       n_div;
    spwm_pkg::t_count r_count;
    spwm_pkg::t_count n_count;

    // On a tick while awake, advance the divider, and the period counter when it meets the prescaler
    always_comb begin
        n_div   = r_div;
        n_count = r_count;
        if (i_tick && !i_cfg.sleep) begin
            if (r_div == i_cfg.prescale) begin
                n_div   = 8'h00;
                n_count = r_count + spwm_pkg::COUNT_BITS'(1);
            end else begin
                n_div = r_div + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_count <= '0;
        end else begin
            r_div   <= n_div;
            r_count <= n_count;
        end
    end

    assign o_count_next = n_count;

endmodule

FILE: sv/spwm_levels.sv
module spwm_levels (
    input  spwm_pkg::t_chan_vec           i_chan,
    input  spwm_pkg::t_count              i_count,
    output logic [spwm_pkg::LEVEL_BITS-1:0] o_levels
);

    // Compare the counter against each channel window, wrapping when on > off
    always_comb begin
        o_levels = '0;
        for (int i = 0; i < spwm_pkg::NUM_CHANNELS; i++) begin
            if (i_chan[i].on_cnt < i_chan[i].off_cnt) begin
                o_levels[i] = (i_count >= i_chan[i].on_cnt) && (i_count < i_chan[i].off_cnt);
            end else if (i_chan[i].on_cnt > i_chan[i].off_cnt) begin
                o_levels[i] = (i_count >= i_chan[i].on_cnt) || (i_count < i_chan[i].off_cnt);
            end else begin
                o_levels[i] = 1'b0;
            end
        end
    end

endmodule
